// ----- rtl/frt_pkg.sv -----
// Shared types and constants for the fault-injection rule table.
// Used by frt_rule_mem, frt_walk and fault_injection_rule_table; no dependencies.
package frt_pkg;

  localparam int MAX_RULES_DEF = 8;
  localparam logic [15:0] ANY_QUEUE = 16'hFFFF;
  localparam logic [3:0]  KIND_NONE = 4'd0;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_CHECK = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_NONE = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] target;
    logic [31:0] trigger;
    logic        once;
    logic [31:0] limit;
    logic [31:0] ops_seen;
    logic [31:0] times_injected;
  } rule_t;

  typedef struct packed {
    logic       inject;
    logic [2:0] fired_rule;
    logic [1:0] status;
    logic [7:0] enabled_mask;
    logic [3:0] rule_total;
  } res_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

// ----- rtl/frt_rule_mem.sv -----
// Rule storage: one synchronous memory of rule entries, registered read.
// Depends on frt_pkg for the entry type.
module frt_rule_mem #(
  parameter int DEPTH = frt_pkg::MAX_RULES_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  frt_pkg::rule_t  wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output frt_pkg::rule_t  rd_data
);

  frt_pkg::rule_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/frt_walk.sv -----
// Request sequencer: appends rules, walks them one per cycle on a check,
// writes updated counters back. Depends on frt_pkg; drives frt_rule_mem.
module frt_walk #(
  parameter int MAX_RULES = frt_pkg::MAX_RULES_DEF,
  parameter int IW        = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1,
  parameter int HW        = $clog2(MAX_RULES + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  logic [1:0]      op,
  input  logic [3:0]      error_type,
  input  logic [15:0]     chk_queue,
  input  logic [15:0]     aim_queue,
  input  logic [31:0]     fire_after,
  input  logic            once_only,
  input  logic [31:0]     inject_limit,
  output logic            mem_wr_en,
  output logic [IW-1:0]   mem_wr_addr,
  output frt_pkg::rule_t  mem_wr_data,
  output logic            mem_rd_en,
  output logic [IW-1:0]   mem_rd_addr,
  input  frt_pkg::rule_t  mem_rd_data,
  output logic            res_valid,
  input  logic            res_ready,
  output frt_pkg::res_t   res
);

  typedef enum logic [1:0] {IDLE, EVAL, FINISH} state_t;

  state_t         state;
  logic [IW-1:0]  idx;
  logic [HW-1:0]  held;
  logic [MAX_RULES-1:0] enabled;
  logic [3:0]     kind_q;
  logic [15:0]    qid_q;
  logic           res_inject;
  logic [2:0]     res_fired;
  logic [1:0]     res_status;

  logic full;
  logic more;
  logic hit;
  logic trig_ok;
  logic lim_hit;
  logic injecting;
  logic disabling;
  frt_pkg::rule_t wb;

  assign full = (held == HW'(MAX_RULES));
  assign more = (HW'(idx) + HW'(1)) < held;

  always_comb begin
    hit = enabled[idx] && (mem_rd_data.kind == kind_q) &&
          (mem_rd_data.target == frt_pkg::ANY_QUEUE || mem_rd_data.target == qid_q);
    trig_ok   = mem_rd_data.ops_seen >= mem_rd_data.trigger;
    lim_hit   = mem_rd_data.times_injected >= mem_rd_data.limit;
    injecting = hit && trig_ok && (!mem_rd_data.once || !lim_hit);
    disabling = hit && trig_ok && mem_rd_data.once && lim_hit;
    wb = mem_rd_data;
    wb.ops_seen = frt_pkg::sat_inc(mem_rd_data.ops_seen);
    if (trig_ok && mem_rd_data.once) begin
      wb.times_injected = frt_pkg::sat_inc(mem_rd_data.times_injected);
    end
  end

  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = idx;
    mem_wr_data = wb;
    mem_rd_en   = 1'b0;
    mem_rd_addr = '0;
    case (state)
      IDLE: begin
        if (req_valid) begin
          if (op == frt_pkg::OP_ADD && error_type != frt_pkg::KIND_NONE && !full) begin
            mem_wr_en                  = 1'b1;
            mem_wr_addr                = held[IW-1:0];
            mem_wr_data.kind           = error_type;
            mem_wr_data.target         = aim_queue;
            mem_wr_data.trigger        = fire_after;
            mem_wr_data.once           = once_only;
            mem_wr_data.limit          = inject_limit;
            mem_wr_data.ops_seen       = '0;
            mem_wr_data.times_injected = '0;
          end
          if (op == frt_pkg::OP_CHECK && held != '0) begin
            mem_rd_en = 1'b1;
          end
        end
      end
      EVAL: begin
        mem_wr_en = hit;
        if (!injecting && more) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = idx + IW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      held    <= '0;
      enabled <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (req_valid) begin
            kind_q     <= error_type;
            qid_q      <= chk_queue;
            idx        <= '0;
            res_inject <= 1'b0;
            res_fired  <= '0;
            case (op)
              frt_pkg::OP_ADD: begin
                state <= FINISH;
                if (error_type == frt_pkg::KIND_NONE) begin
                  res_status <= frt_pkg::ST_NONE;
                end else if (full) begin
                  res_status <= frt_pkg::ST_FULL;
                end else begin
                  res_status            <= frt_pkg::ST_DONE;
                  enabled[held[IW-1:0]] <= 1'b1;
                  held                  <= held + HW'(1);
                end
              end
              frt_pkg::OP_CHECK: begin
                res_status <= frt_pkg::ST_DONE;
                state      <= (held != '0) ? EVAL : FINISH;
              end
              frt_pkg::OP_CLEAR: begin
                res_status <= frt_pkg::ST_DONE;
                state      <= FINISH;
                enabled    <= '0;
                held       <= '0;
              end
              default: begin
                res_status <= frt_pkg::ST_DONE;
                state      <= FINISH;
              end
            endcase
          end
        end
        EVAL: begin
          if (disabling) begin
            enabled[idx] <= 1'b0;
          end
          if (injecting) begin
            res_inject <= 1'b1;
            res_fired  <= 3'(idx);
            state      <= FINISH;
          end else if (more) begin
            idx <= idx + IW'(1);
          end else begin
            state <= FINISH;
          end
        end
        FINISH: begin
          if (res_ready) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign req_ready        = (state == IDLE);
  assign res_valid        = (state == FINISH);
  assign res.inject       = res_inject;
  assign res.fired_rule   = res_fired;
  assign res.status       = res_status;
  assign res.enabled_mask = 8'(enabled);
  assign res.rule_total   = 4'(held);

endmodule

// ----- rtl/fault_injection_rule_table.sv -----
// Fault-injection rule table top: sequencer, rule memory and response register.
// Add, clear, unused codes and a check of an empty table go straight to the response
// state once the request is taken; any other check first visits k rules, then answers,
// k = rules visited (1 up to rules held).
// One request at a time; the next can be taken from the cycle after the response is loaded,
// and a check walks one rule a cycle through the memory read port.
// Reset empties the table and drops any pending response; rule entries stay unwritten.
module fault_injection_rule_table #(
  parameter int MAX_RULES = frt_pkg::MAX_RULES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [1:0]  op,
  input  logic [3:0]  error_type,
  input  logic [15:0] chk_queue,
  input  logic [15:0] aim_queue,
  input  logic [31:0] fire_after,
  input  logic        once_only,
  input  logic [31:0] inject_limit,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic        inject,
  output logic [2:0]  fired_rule,
  output logic [1:0]  status,
  output logic [7:0]  enabled_mask,
  output logic [3:0]  rule_total
);

  localparam int IW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;

  logic            mem_wr_en;
  logic [IW-1:0]   mem_wr_addr;
  frt_pkg::rule_t  mem_wr_data;
  logic            mem_rd_en;
  logic [IW-1:0]   mem_rd_addr;
  frt_pkg::rule_t  mem_rd_data;
  logic            res_valid;
  logic            res_ready;
  frt_pkg::res_t   res;

  frt_walk #(
    .MAX_RULES (MAX_RULES)
  ) u_walk (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .op            (op),
    .error_type    (error_type),
    .chk_queue     (chk_queue),
    .aim_queue     (aim_queue),
    .fire_after    (fire_after),
    .once_only     (once_only),
    .inject_limit  (inject_limit),
    .mem_wr_en     (mem_wr_en),
    .mem_wr_addr   (mem_wr_addr),
    .mem_wr_data   (mem_wr_data),
    .mem_rd_en     (mem_rd_en),
    .mem_rd_addr   (mem_rd_addr),
    .mem_rd_data   (mem_rd_data),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res)
  );

  frt_rule_mem #(
    .DEPTH (MAX_RULES)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  assign res_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= res_valid;
      if (res_valid) begin
        inject       <= res.inject;
        fired_rule   <= res.fired_rule;
        status       <= res.status;
        enabled_mask <= res.enabled_mask;
        rule_total   <= res.rule_total;
      end
    end
  end

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while a request is in flight");

  a_inject_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && inject |-> status == frt_pkg::ST_DONE)
    else $error("injecting response carries an add status");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("pending response lost or changed");

endmodule
